[hw/rtl/argtok_pkg.sv]
// Shared types and constants for the argument tokenizer.
// Holds the result record, comment-phase states, end codes and character helpers.
// No dependencies.
package argtok_pkg;

    // Configuration register indexes
    localparam logic [1:0] REG_OPTIONS   = 2'd0;
    localparam logic [1:0] REG_DELIMITER = 2'd1;
    localparam logic [1:0] REG_CAPACITY  = 2'd2;

    // Register widths and reset values
    localparam int OPT_W = 4;
    localparam int CAP_W = 13;
    localparam logic [OPT_W-1:0] OPTIONS_RST   = 4'd0;
    localparam logic [7:0]       DELIMITER_RST = 8'd44;
    localparam logic [CAP_W-1:0] CAPACITY_RST  = 13'd1024;

    // Option bits
    localparam int OPT_SKIP_COMMENTS = 0;
    localparam int OPT_BREAK_DELIM   = 1;
    localparam int OPT_BREAK_CRLF    = 2;
    localparam int OPT_BREAK_EMPTY   = 3;

    // End-of-argument codes
    localparam logic [2:0] END_OK       = 3'd0;
    localparam logic [2:0] END_COMPLETE = 3'd1;
    localparam logic [2:0] END_DELIM    = 3'd2;
    localparam logic [2:0] END_CRLF     = 3'd3;
    localparam logic [2:0] END_EMPTY    = 3'd4;

    // Record kinds
    localparam logic KIND_CONTENT = 1'b0;
    localparam logic KIND_END     = 1'b1;

    // Characters
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    // Result queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int MAX_RESULTS = 3;

    // Comment tracking
    typedef enum logic [2:0] {
        PH_TEXT  = 3'd0,
        PH_HELD  = 3'd1,
        PH_LINE  = 3'd2,
        PH_BLOCK = 3'd3,
        PH_STAR  = 3'd4
    } phase_t;

    // One result record
    typedef struct packed {
        logic        kind;
        logic [7:0]  out_char;
        logic [15:0] position;
        logic [2:0]  end_code;
        logic [15:0] arg_length;
        logic        truncated;
    } rec_t;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

    function automatic logic is_eol(input logic [7:0] c);
        return (c == CH_CR) || (c == CH_LF);
    endfunction

endpackage

[hw/rtl/argument_tokenizer.sv]
// Argument tokenizer: splits a character stream into argument records.
// Output: the first result of an item is offered on m_ the cycle after the item is
//   accepted if no result is queued ahead of it, else it waits behind those results.
// Flow: one item per cycle while items yield at most one result each and m_ready stays
//   high; results leave one per cycle while m_ready is high, through a four-entry queue,
//   and s_ready drops while more than one result is queued.
// Reset (aresetn low, synchronous): argument state, comment phase, queue and registers
//   return to their defaults. Depends on argtok_pkg.
module argument_tokenizer #(
    parameter int LENGTH_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [12:0] cfg_data,
    // character input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_ch,
    input  logic        s_last_char,
    // result output
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [7:0]  m_out_char,
    output logic [15:0] m_position,
    output logic [2:0]  m_end_code,
    output logic [15:0] m_arg_length,
    output logic        m_truncated,
    output logic        m_last_of_run
);

    localparam int SAT_W = (LENGTH_BITS > 16) ? LENGTH_BITS : 16;
    localparam int CMP_W = (LENGTH_BITS > argtok_pkg::CAP_W) ? LENGTH_BITS
                                                             : argtok_pkg::CAP_W;
    localparam int CNT_W = argtok_pkg::QUEUE_AW + 1;

    typedef struct packed {
        logic                   in_quote;
        logic [LENGTH_BITS-1:0] count;
        logic                   tsm;
        logic [LENGTH_BITS-1:0] lbs;
    } arg_st_t;

    typedef struct packed {
        arg_st_t            st;
        logic [1:0]         n;
        argtok_pkg::rec_t   r0;
        argtok_pkg::rec_t   r1;
    } take_t;

    // ---------------------------------------------------------------
    // Helpers
    // ---------------------------------------------------------------
    function automatic logic [15:0] sat16(input logic [LENGTH_BITS-1:0] v);
        logic [SAT_W-1:0] w;
        w = SAT_W'(v);
        if (w > SAT_W'(16'hFFFF)) begin
            return 16'hFFFF;
        end
        return w[15:0];
    endfunction

    function automatic logic at_cap(input logic [LENGTH_BITS-1:0] v,
                                    input logic [argtok_pkg::CAP_W-1:0] cap);
        return CMP_W'(v) >= CMP_W'(cap);
    endfunction

    function automatic logic [LENGTH_BITS-1:0] inc_sat(input logic [LENGTH_BITS-1:0] v);
        return (v == '1) ? v : v + LENGTH_BITS'(1);
    endfunction

    function automatic argtok_pkg::rec_t content_rec(input logic [7:0] c,
                                                     input logic [LENGTH_BITS-1:0] cnt,
                                                     input logic [argtok_pkg::CAP_W-1:0] cap);
        argtok_pkg::rec_t r;
        r            = '0;
        r.kind       = argtok_pkg::KIND_CONTENT;
        r.out_char   = c;
        r.position   = sat16(cnt);
        r.truncated  = at_cap(cnt, cap);
        return r;
    endfunction

    function automatic argtok_pkg::rec_t end_rec(input logic [2:0] code,
                                                 input logic [LENGTH_BITS-1:0] len,
                                                 input logic [argtok_pkg::CAP_W-1:0] cap);
        argtok_pkg::rec_t r;
        r            = '0;
        r.kind       = argtok_pkg::KIND_END;
        r.end_code   = code;
        r.arg_length = sat16(len);
        r.truncated  = at_cap(len, cap);
        return r;
    endfunction

    // One resolved character: state update and up to two records
    function automatic take_t take_char(input arg_st_t st, input logic [7:0] c,
                                        input logic [argtok_pkg::OPT_W-1:0] opt,
                                        input logic [7:0] delim,
                                        input logic [argtok_pkg::CAP_W-1:0] cap);
        take_t r;
        logic  done;
        r.st = st;
        r.n  = 2'd0;
        r.r0 = '0;
        r.r1 = '0;
        done = 1'b0;
        // trailing blanks after content
        if (st.tsm) begin
            if (c == delim) begin
                r.r0 = end_rec(argtok_pkg::END_DELIM, st.lbs, cap);
                r.n  = 2'd1;
                r.st = '0;
                done = 1'b1;
            end else if (argtok_pkg::is_blank(c)) begin
                r.r0       = content_rec(c, st.count, cap);
                r.n        = 2'd1;
                r.st.count = inc_sat(st.count);
                done       = 1'b1;
            end else begin
                r.st.tsm = 1'b0;
            end
        end
        if (!done) begin
            if (opt[argtok_pkg::OPT_BREAK_DELIM] && (c == delim)) begin
                r.r0 = end_rec(argtok_pkg::END_DELIM, r.st.count, cap);
                r.n  = 2'd1;
                r.st = '0;
            end else if (argtok_pkg::is_eol(c)) begin
                if (r.st.count != '0) begin
                    r.r0 = end_rec(argtok_pkg::END_OK, r.st.count, cap);
                    r.n  = 2'd1;
                    r.st = '0;
                end
                if (opt[argtok_pkg::OPT_BREAK_CRLF]) begin
                    if (r.n == 2'd0) begin
                        r.r0 = end_rec(argtok_pkg::END_CRLF, '0, cap);
                    end else begin
                        r.r1 = end_rec(argtok_pkg::END_CRLF, '0, cap);
                    end
                    r.n  = r.n + 2'd1;
                    r.st = '0;
                end else begin
                    r.st.in_quote = 1'b0;
                end
            end else if (!r.st.in_quote && argtok_pkg::is_blank(c)) begin
                if (r.st.count != '0) begin
                    if (opt[argtok_pkg::OPT_BREAK_DELIM]) begin
                        r.st.tsm   = 1'b1;
                        r.st.lbs   = r.st.count;
                        r.r0       = content_rec(c, r.st.count, cap);
                        r.n        = 2'd1;
                        r.st.count = inc_sat(r.st.count);
                    end else begin
                        r.r0 = end_rec(argtok_pkg::END_OK, r.st.count, cap);
                        r.n  = 2'd1;
                        r.st = '0;
                    end
                end
            end else if (c == argtok_pkg::CH_QUOTE) begin
                if (r.st.in_quote) begin
                    if (opt[argtok_pkg::OPT_BREAK_EMPTY]) begin
                        r.r0 = end_rec(argtok_pkg::END_EMPTY, r.st.count, cap);
                        r.n  = 2'd1;
                        r.st = '0;
                    end else begin
                        r.st.in_quote = 1'b0;
                    end
                end else begin
                    r.st.in_quote = 1'b1;
                end
            end else begin
                r.r0       = content_rec(c, r.st.count, cap);
                r.n        = 2'd1;
                r.st.count = inc_sat(r.st.count);
            end
        end
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [argtok_pkg::OPT_W-1:0] opt_reg;
    logic [7:0]                   delim_reg;
    logic [argtok_pkg::CAP_W-1:0] cap_reg;

    arg_st_t              st_reg, st_next;
    argtok_pkg::phase_t   ph_reg, ph_next;

    argtok_pkg::rec_t     q_rec_reg  [argtok_pkg::QUEUE_DEPTH];
    logic                 q_last_reg [argtok_pkg::QUEUE_DEPTH];
    logic [argtok_pkg::QUEUE_AW-1:0] head_reg, tail_reg;
    logic [CNT_W-1:0]     cnt_reg;

    argtok_pkg::rec_t     res [argtok_pkg::MAX_RESULTS];
    logic [1:0]           res_n;

    logic accept, pop;

    assign cfg_ready = 1'b1;
    assign s_ready   = (cnt_reg <= CNT_W'(1));
    assign accept    = s_valid && s_ready;
    assign m_valid   = (cnt_reg != '0);
    assign pop       = m_valid && m_ready;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            opt_reg   <= argtok_pkg::OPTIONS_RST;
            delim_reg <= argtok_pkg::DELIMITER_RST;
            cap_reg   <= argtok_pkg::CAPACITY_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                argtok_pkg::REG_OPTIONS:   opt_reg   <= cfg_data[argtok_pkg::OPT_W-1:0];
                argtok_pkg::REG_DELIMITER: delim_reg <= cfg_data[7:0];
                argtok_pkg::REG_CAPACITY:  cap_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Per-item pass: comment tracking, held slash, character, stream end
    // ---------------------------------------------------------------
    always_comb begin
        arg_st_t st;
        take_t   ta, tb;
        logic    c_zero, end_run, do_a, do_b, hold_chk, last_end;
        logic [1:0] n;

        st       = st_reg;
        ph_next  = ph_reg;
        c_zero   = (s_ch == argtok_pkg::CH_NUL);
        end_run  = c_zero || s_last_char;
        do_a     = 1'b0;
        do_b     = 1'b0;
        hold_chk = 1'b0;
        last_end = 1'b0;
        n        = 2'd0;
        for (int i = 0; i < argtok_pkg::MAX_RESULTS; i++) begin
            res[i] = '0;
        end

        // advance the comment phase
        case (ph_reg)
            argtok_pkg::PH_HELD: begin
                if (c_zero) begin
                    do_a = 1'b1;
                end else if (s_ch == argtok_pkg::CH_SLASH) begin
                    ph_next = argtok_pkg::PH_LINE;
                end else if (s_ch == argtok_pkg::CH_STAR) begin
                    ph_next = argtok_pkg::PH_BLOCK;
                end else begin
                    ph_next  = argtok_pkg::PH_TEXT;
                    do_a     = 1'b1;
                    hold_chk = 1'b1;
                end
            end
            argtok_pkg::PH_LINE: begin
                if (!c_zero && argtok_pkg::is_eol(s_ch)) begin
                    ph_next = argtok_pkg::PH_TEXT;
                    do_b    = 1'b1;
                end
            end
            argtok_pkg::PH_BLOCK: begin
                if (!c_zero) begin
                    ph_next = (s_ch == argtok_pkg::CH_STAR) ? argtok_pkg::PH_STAR
                                                            : argtok_pkg::PH_BLOCK;
                end
            end
            argtok_pkg::PH_STAR: begin
                if (!c_zero) begin
                    if (s_ch == argtok_pkg::CH_SLASH) begin
                        ph_next = argtok_pkg::PH_TEXT;
                    end else if (s_ch == argtok_pkg::CH_STAR) begin
                        ph_next = argtok_pkg::PH_STAR;
                    end else begin
                        ph_next = argtok_pkg::PH_BLOCK;
                    end
                end
            end
            default: begin
                if (!c_zero) begin
                    ph_next  = argtok_pkg::PH_TEXT;
                    hold_chk = 1'b1;
                end
            end
        endcase

        // hold a slash that may open a comment
        if (hold_chk) begin
            if (opt_reg[argtok_pkg::OPT_SKIP_COMMENTS] && (s_ch == argtok_pkg::CH_SLASH)
                    && !s_last_char) begin
                ph_next = argtok_pkg::PH_HELD;
            end else begin
                do_b = 1'b1;
            end
        end

        // release the held slash as content
        ta = take_char(st, argtok_pkg::CH_SLASH, opt_reg, delim_reg, cap_reg);
        if (do_a) begin
            st = ta.st;
            for (int k = 0; k < 2; k++) begin
                if ((2'(k) < ta.n) && (n < 2'd3)) begin
                    res[n]   = (k == 0) ? ta.r0 : ta.r1;
                    last_end = res[n].kind;
                    n        = n + 2'd1;
                end
            end
        end

        // take the current character
        tb = take_char(st, s_ch, opt_reg, delim_reg, cap_reg);
        if (do_b) begin
            st = tb.st;
            for (int k = 0; k < 2; k++) begin
                if ((2'(k) < tb.n) && (n < 2'd3)) begin
                    res[n]   = (k == 0) ? tb.r0 : tb.r1;
                    last_end = res[n].kind;
                    n        = n + 2'd1;
                end
            end
        end

        // close the stream
        if (end_run) begin
            if (!last_end && (n < 2'd3)) begin
                res[n] = end_rec(argtok_pkg::END_COMPLETE, st.tsm ? st.lbs : st.count,
                                 cap_reg);
                n      = n + 2'd1;
            end
            st      = '0;
            ph_next = argtok_pkg::PH_TEXT;
        end

        st_next = st;
        res_n   = n;
    end

    // Update argument state on each accepted item
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= '0;
            ph_reg <= argtok_pkg::PH_TEXT;
        end else if (accept) begin
            st_reg <= st_next;
            ph_reg <= ph_next;
        end
    end

    // ---------------------------------------------------------------
    // Result queue
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int i = 0; i < argtok_pkg::MAX_RESULTS; i++) begin
                if (2'(i) < res_n) begin
                    q_rec_reg[tail_reg + argtok_pkg::QUEUE_AW'(i)]  <= res[i];
                    q_last_reg[tail_reg + argtok_pkg::QUEUE_AW'(i)] <= (2'(i) == res_n - 2'd1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            if (accept) begin
                tail_reg <= tail_reg + argtok_pkg::QUEUE_AW'(res_n);
            end
            if (pop) begin
                head_reg <= head_reg + argtok_pkg::QUEUE_AW'(1);
            end
            cnt_reg <= cnt_reg + (accept ? CNT_W'(res_n) : CNT_W'(0))
                               - (pop ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Drive the result ports from the queue head
    assign m_kind        = q_rec_reg[head_reg].kind;
    assign m_out_char    = q_rec_reg[head_reg].out_char;
    assign m_position    = q_rec_reg[head_reg].position;
    assign m_end_code    = q_rec_reg[head_reg].end_code;
    assign m_arg_length  = q_rec_reg[head_reg].arg_length;
    assign m_truncated   = q_rec_reg[head_reg].truncated;
    assign m_last_of_run = q_last_reg[head_reg];

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_queue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(argtok_pkg::QUEUE_DEPTH))
        else $error("result queue overflow");

    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((s_ch == argtok_pkg::CH_NUL) || s_last_char)) |=>
            ((st_reg == '0) && (ph_reg == argtok_pkg::PH_TEXT)))
        else $error("state not cleared at stream end");

    a_end_has_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && ((s_ch == argtok_pkg::CH_NUL) || s_last_char)) |=> m_valid)
        else $error("stream end produced no result");

endmodule

[sim/argument_tokenizer_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for argument_tokenizer: directed and random character streams.
// A record board predicts every content and end record; depends on argtok_pkg and the RTL.
module argument_tokenizer_test;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 300;

    // One expected or observed result
    typedef struct packed {
        argtok_pkg::rec_t rec;
        logic             last_of_run;
    } arg_result_t;

    // Tracks tokenizer state per accepted character and checks the result stream
    class record_board;
        logic [argtok_pkg::OPT_W-1:0] options;
        logic [7:0]                   delimiter;
        logic [argtok_pkg::CAP_W-1:0] capacity;
        bit                           in_quote;
        logic [15:0]                  run_length;
        argtok_pkg::phase_t           phase;
        bit                           trim_mode;
        logic [15:0]                  trimmed_length;
        bit                           last_was_end;
        arg_result_t                  step_recs[$];
        arg_result_t                  pending_records[$];
        int                           errors;

        function new();
            options   = argtok_pkg::OPTIONS_RST;
            delimiter = argtok_pkg::DELIMITER_RST;
            capacity  = argtok_pkg::CAPACITY_RST;
            phase     = argtok_pkg::PH_TEXT;
            errors    = 0;
            clear_arg();
        endfunction

        function void set_register(logic [1:0] index, logic [12:0] data);
            case (index)
                argtok_pkg::REG_OPTIONS:   options = data[argtok_pkg::OPT_W-1:0];
                argtok_pkg::REG_DELIMITER: delimiter = data[7:0];
                argtok_pkg::REG_CAPACITY:  capacity = data;
                default: ;
            endcase
        endfunction

        function void clear_arg();
            in_quote       = 0;
            run_length     = '0;
            trim_mode      = 0;
            trimmed_length = '0;
        endfunction

        // Append one record for this character, at most three per character
        function void push_record(logic kind, logic [7:0] c, logic [15:0] pos,
                                  logic [2:0] code, logic [15:0] len, logic trunc);
            arg_result_t r;
            if (step_recs.size() >= argtok_pkg::MAX_RESULTS)
                return;
            r.rec.kind       = kind;
            r.rec.out_char   = c;
            r.rec.position   = pos;
            r.rec.end_code   = code;
            r.rec.arg_length = len;
            r.rec.truncated  = trunc;
            r.last_of_run    = 1'b0;
            step_recs.push_back(r);
            last_was_end = (kind == argtok_pkg::KIND_END);
        endfunction

        function void push_content(logic [7:0] c);
            push_record(argtok_pkg::KIND_CONTENT, c, run_length, argtok_pkg::END_OK, 16'd0,
                        run_length >= capacity);
            if (run_length != 16'hFFFF)
                run_length++;
        endfunction

        function void close_arg(logic [2:0] code, logic [15:0] len);
            push_record(argtok_pkg::KIND_END, argtok_pkg::CH_NUL, 16'd0, code, len,
                        len >= capacity);
            clear_arg();
        endfunction

        // Character after comment handling
        function void take_char(logic [7:0] c);
            if (trim_mode) begin
                if (c == delimiter) begin
                    close_arg(argtok_pkg::END_DELIM, trimmed_length);
                    return;
                end
                if (c == argtok_pkg::CH_SPACE || c == argtok_pkg::CH_TAB) begin
                    push_content(c);
                    return;
                end
                trim_mode = 0;
            end
            if (options[argtok_pkg::OPT_BREAK_DELIM] && c == delimiter) begin
                close_arg(argtok_pkg::END_DELIM, run_length);
                return;
            end
            if (c == argtok_pkg::CH_CR || c == argtok_pkg::CH_LF) begin
                if (run_length != 0)
                    close_arg(argtok_pkg::END_OK, run_length);
                if (options[argtok_pkg::OPT_BREAK_CRLF])
                    close_arg(argtok_pkg::END_CRLF, 16'd0);
                else
                    in_quote = 0;
                return;
            end
            if (!in_quote && (c == argtok_pkg::CH_SPACE || c == argtok_pkg::CH_TAB)) begin
                if (run_length != 0) begin
                    if (options[argtok_pkg::OPT_BREAK_DELIM]) begin
                        // keep blanks as content but remember the trimmed length
                        trim_mode      = 1;
                        trimmed_length = run_length;
                        push_content(c);
                    end else begin
                        close_arg(argtok_pkg::END_OK, run_length);
                    end
                end
                return;
            end
            if (c == argtok_pkg::CH_QUOTE) begin
                if (in_quote) begin
                    if (options[argtok_pkg::OPT_BREAK_EMPTY])
                        close_arg(argtok_pkg::END_EMPTY, run_length);
                    else
                        in_quote = 0;
                end else begin
                    in_quote = 1;
                end
                return;
            end
            push_content(c);
        endfunction

        // Comment tracking in front of the tokenizer
        function void feed_char(logic [7:0] c, bit last);
            case (phase)
                argtok_pkg::PH_HELD: begin
                    if (c == argtok_pkg::CH_SLASH) begin
                        phase = argtok_pkg::PH_LINE;
                        return;
                    end
                    if (c == argtok_pkg::CH_STAR) begin
                        phase = argtok_pkg::PH_BLOCK;
                        return;
                    end
                    phase = argtok_pkg::PH_TEXT;
                    take_char(argtok_pkg::CH_SLASH);
                end
                argtok_pkg::PH_LINE: begin
                    if (c == argtok_pkg::CH_CR || c == argtok_pkg::CH_LF) begin
                        phase = argtok_pkg::PH_TEXT;
                        take_char(c);
                    end
                    return;
                end
                argtok_pkg::PH_BLOCK: begin
                    phase = (c == argtok_pkg::CH_STAR) ? argtok_pkg::PH_STAR
                                                       : argtok_pkg::PH_BLOCK;
                    return;
                end
                argtok_pkg::PH_STAR: begin
                    phase = (c == argtok_pkg::CH_SLASH) ? argtok_pkg::PH_TEXT
                          : (c == argtok_pkg::CH_STAR)  ? argtok_pkg::PH_STAR
                                                        : argtok_pkg::PH_BLOCK;
                    return;
                end
                default: phase = argtok_pkg::PH_TEXT;
            endcase
            if (options[argtok_pkg::OPT_SKIP_COMMENTS] && c == argtok_pkg::CH_SLASH
                    && !last) begin
                phase = argtok_pkg::PH_HELD;
                return;
            end
            take_char(c);
        endfunction

        // Predict the records caused by one accepted character
        function void note_char(logic [7:0] c, bit last);
            step_recs.delete();
            last_was_end = 0;
            if (c != argtok_pkg::CH_NUL)
                feed_char(c, last);
            if (c == argtok_pkg::CH_NUL || last) begin
                // flush a held slash, then close the stream
                if (phase == argtok_pkg::PH_HELD) begin
                    phase = argtok_pkg::PH_TEXT;
                    take_char(argtok_pkg::CH_SLASH);
                end
                if (!(step_recs.size() > 0 && last_was_end))
                    close_arg(argtok_pkg::END_COMPLETE,
                              trim_mode ? trimmed_length : run_length);
                clear_arg();
                phase = argtok_pkg::PH_TEXT;
            end
            if (step_recs.size() > 0)
                step_recs[step_recs.size() - 1].last_of_run = 1'b1;
            foreach (step_recs[i])
                pending_records.push_back(step_recs[i]);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, name, want, got);
            end
        endfunction

        function void check_record(arg_result_t got);
            arg_result_t want;
            if (pending_records.size() == 0) begin
                errors++;
                $display("%0t: unexpected record, expected none, actual kind %0d char %0d",
                         $time, got.rec.kind, got.rec.out_char);
                return;
            end
            want = pending_records.pop_front();
            compare_field("kind", want.rec.kind, got.rec.kind);
            compare_field("out_char", want.rec.out_char, got.rec.out_char);
            compare_field("position", want.rec.position, got.rec.position);
            compare_field("end_code", want.rec.end_code, got.rec.end_code);
            compare_field("arg_length", want.rec.arg_length, got.rec.arg_length);
            compare_field("truncated", want.rec.truncated, got.rec.truncated);
            compare_field("last_of_run", want.last_of_run, got.last_of_run);
        endfunction

        function int pending();
            return pending_records.size();
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [12:0] cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_ch = '0;
    logic        s_last_char = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic        m_kind;
    logic [7:0]  m_out_char;
    logic [15:0] m_position;
    logic [2:0]  m_end_code;
    logic [15:0] m_arg_length;
    logic        m_truncated;
    logic        m_last_of_run;

    record_board board;
    int          cycle_count = 0;
    int          chars_sent = 0;
    bit          source_burst = 0;
    bit          hold_off_request = 0;
    logic [7:0]  cur_delim = argtok_pkg::DELIMITER_RST;

    argument_tokenizer DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_ch(s_ch),
        .s_last_char(s_last_char),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_kind(m_kind),
        .m_out_char(m_out_char),
        .m_position(m_position),
        .m_end_code(m_end_code),
        .m_arg_length(m_arg_length),
        .m_truncated(m_truncated),
        .m_last_of_run(m_last_of_run)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Check every record taken from the output
    always @(posedge aclk) begin
        arg_result_t got;
        if (aresetn && m_valid && m_ready) begin
            got.rec.kind       = m_kind;
            got.rec.out_char   = m_out_char;
            got.rec.position   = m_position;
            got.rec.end_code   = m_end_code;
            got.rec.arg_length = m_arg_length;
            got.rec.truncated  = m_truncated;
            got.last_of_run    = m_last_of_run;
            board.check_record(got);
        end
    end

    // Result sink: random stalls, stretches without stalls, one long hold-off
    initial begin
        int  stall;
        bit  sink_burst;
        sink_burst = 0;
        while (aresetn !== 1'b1)
            @(posedge aclk);
        forever begin
            if ($urandom_range(0, 15) == 0)
                sink_burst = !sink_burst;
            if (hold_off_request) begin
                stall = HOLD_CYCLES;
                hold_off_request = 0;
            end else begin
                stall = sink_burst ? 0 : $urandom_range(0, 18);
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid)
                @(posedge aclk);
        end
    end

    task automatic write_reg(logic [1:0] index, logic [12:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        board.set_register(index, data);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic configure(logic [argtok_pkg::OPT_W-1:0] opts, logic [7:0] delim,
                             logic [12:0] cap);
        write_reg(argtok_pkg::REG_OPTIONS, 13'(opts));
        write_reg(argtok_pkg::REG_DELIMITER, 13'(delim));
        write_reg(argtok_pkg::REG_CAPACITY, cap);
        cur_delim = delim;
    endtask

    // Offer one character after a random gap and hold it until taken
    task automatic send_char(logic [7:0] c, bit last);
        int gap;
        gap = source_burst ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_ch        <= c;
        s_last_char <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        board.note_char(c, last);
        chars_sent++;
    endtask

    task automatic send_text(string text);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], 1'b0);
    endtask

    task automatic send_word(int max_len);
        int n;
        n = $urandom_range(1, max_len);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0)
                send_char(8'($urandom_range(48, 57)), 1'b0);
            else
                send_char(8'($urandom_range(97, 122)), 1'b0);
        end
    endtask

    // Drain all expected records, then let the pipeline settle
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Mostly well-formed argument text with some noise mixed in
    task automatic random_stream(int count);
        int target;
        target = chars_sent + count;
        while (chars_sent < target) begin
            if ($urandom_range(0, 9) == 0)
                source_burst = !source_burst;
            case ($urandom_range(0, 11))
                0, 1, 2: send_word(6);
                3: begin
                    send_char(argtok_pkg::CH_QUOTE, 1'b0);
                    if ($urandom_range(0, 3) != 0)
                        send_word(4);
                    if ($urandom_range(0, 1))
                        send_char(argtok_pkg::CH_SPACE, 1'b0);
                    send_char(argtok_pkg::CH_QUOTE, 1'b0);
                end
                4: begin
                    repeat ($urandom_range(0, 2))
                        send_char($urandom_range(0, 1) ? argtok_pkg::CH_SPACE
                                                       : argtok_pkg::CH_TAB, 1'b0);
                    send_char(cur_delim, 1'b0);
                    if ($urandom_range(0, 1))
                        send_char(argtok_pkg::CH_SPACE, 1'b0);
                end
                5: repeat ($urandom_range(1, 2))
                    send_char($urandom_range(0, 1) ? argtok_pkg::CH_SPACE
                                                   : argtok_pkg::CH_TAB, 1'b0);
                6: begin
                    if ($urandom_range(0, 1))
                        send_char(argtok_pkg::CH_CR, 1'b0);
                    send_char(argtok_pkg::CH_LF, 1'b0);
                end
                7: begin
                    send_text("//");
                    send_word(4);
                    send_char($urandom_range(0, 1) ? argtok_pkg::CH_LF
                                                   : argtok_pkg::CH_CR, 1'b0);
                end
                8: begin
                    send_text("/*");
                    send_word(3);
                    repeat ($urandom_range(1, 2))
                        send_char(argtok_pkg::CH_STAR, 1'b0);
                    if ($urandom_range(0, 3) != 0)
                        send_char(argtok_pkg::CH_SLASH, 1'b0);
                end
                9: begin
                    // lone slash followed by ordinary text or a stream end
                    send_char(argtok_pkg::CH_SLASH, $urandom_range(0, 3) == 0);
                    if ($urandom_range(0, 1))
                        send_word(2);
                end
                10: begin
                    if ($urandom_range(0, 2) == 0)
                        send_char(argtok_pkg::CH_NUL, 1'($urandom_range(0, 1)));
                    else
                        send_char(8'($urandom_range(97, 122)), 1'b1);
                end
                default: send_char(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            endcase
        end
    endtask

    function automatic logic [7:0] pick_delimiter();
        case ($urandom_range(0, 5))
            0: return ",";
            1: return ";";
            2: return argtok_pkg::CH_SPACE;
            3: return argtok_pkg::CH_QUOTE;
            4: return argtok_pkg::CH_SLASH;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        board = new();
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every option on, comma delimiter, tiny capacity
        configure(4'b1111, ",", 13'd2);
        send_text("abc ,");
        send_text("\"x \"");
        send_text("/q//z");
        send_char(argtok_pkg::CH_CR, 1'b0);
        send_text("/***/");
        send_char(argtok_pkg::CH_TAB, 1'b0);
        send_text("k/");
        send_char(argtok_pkg::CH_NUL, 1'b0);
        send_char("m", 1'b1);
        send_char(argtok_pkg::CH_SLASH, 1'b1);
        send_char(8'hFF, 1'b1);
        wait_drained();

        // Extreme settings
        configure(4'b0000, 8'hFF, 13'd4096);
        random_stream(35);
        wait_drained();
        configure(4'b1111, 8'h00, 13'd1);
        random_stream(35);
        wait_drained();

        // Random settings; one phase runs against a long output hold-off
        for (int phase_no = 0; phase_no < 4; phase_no++) begin
            configure(4'($urandom_range(0, 15)), pick_delimiter(),
                      $urandom_range(0, 3) == 0 ? 13'($urandom_range(1, 4096))
                                                : 13'($urandom_range(1, 8)));
            if (phase_no == 1) begin
                source_burst = 1;
                hold_off_request = 1;
            end
            random_stream(32);
            wait_drained();
        end

        repeat (8) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
